@@ design/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Sizes, request and status codes, and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  // storage sizes
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed widths of the item fields
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int ENT_W  = 11;
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [VAL_W-1:0]      val_t;
  typedef logic [ENT_W-1:0]      ent_t;

  // request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_DROP   = 3'd1,
    FN_INSERT = 3'd2,
    FN_REMOVE = 3'd3,
    FN_WRITE  = 3'd4,
    FN_READ   = 3'd5,
    FN_SEARCH = 3'd6,
    FN_NOP    = 3'd7
  } func_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // read address source
  typedef enum logic {
    RD_PTR,
    RD_IDX
  } rd_src_e;

  // walk pointer load
  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_CNT_M1,
    PTR_IDX_P1
  } ptr_init_e;

  // memory write selection
  typedef enum logic [1:0] {
    WR_NONE,
    WR_AT_COUNT,
    WR_AT_IDX,
    WR_SHIFT
  } wr_op_e;

  // entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // which extra fields a result carries
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_READ,
    RES_FOUND
  } res_kind_e;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      rd_issue;
    rd_src_e   rd_src;
    ptr_init_e ptr_init;
    logic      ptr_step;
    wr_op_e    wr_op;
    cnt_op_e   cnt_op;
    logic      finish;
    status_e   res_status;
    res_kind_e res_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e   func;
    status_e err;
    logic    empty;
    logic    idx_eq_count;
    logic    idx_last;
    logic    ptr_last;
    logic    rd_pend;
    logic    match;
    logic    res_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ design/ils_if.sv @@
// ----------------------------------------------------------------------------
// ils_req_if / ils_rsp_if: request and response channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ils_req_if;
  logic               valid;
  logic               ready;
  ils_pkg::func_e     func;
  ils_pkg::idx_t      index;
  ils_pkg::val_t      value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface ils_rsp_if;
  logic               valid;
  logic               ready;
  ils_pkg::status_e   status;
  ils_pkg::val_t      read_value;
  logic               found;
  ils_pkg::idx_t      found_index;
  ils_pkg::ent_t      entry_count;

  modport source (output valid, output status, output read_value, output found,
                  output found_index, output entry_count, input ready);
  modport sink   (input valid, input status, input read_value, input found,
                  input found_index, input entry_count, output ready);
endinterface

`default_nettype wire

@@ design/ils_ctrl.sv @@
// ----------------------------------------------------------------------------
// ils_ctrl: sequencer of the indexed list store
// Decodes each request and steps the datapath through single writes,
// memory walks for insert, remove and search, and result capture.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output      logic          req_ready_o,
  input  wire ils_pkg::sts_t sts_i,
  output      ils_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_RDWAIT,
    S_SEARCH,
    S_SWAIT
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // take a request only with the result slot free or draining
  assign req_ready_o = (state_q == S_IDLE) && !sts_i.res_busy;

  // command decode
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.rd_src      = ils_pkg::RD_PTR;
    cmd_o.ptr_init    = ils_pkg::PTR_HOLD;
    cmd_o.wr_op       = ils_pkg::WR_NONE;
    cmd_o.cnt_op      = ils_pkg::CNT_HOLD;
    cmd_o.res_status  = ils_pkg::ST_OK;
    cmd_o.res_kind    = ils_pkg::RES_PLAIN;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        if (sts_i.err != ils_pkg::ST_OK) begin
          cmd_o.finish     = 1'b1;
          cmd_o.res_status = sts_i.err;
          state_d          = S_IDLE;
        end else begin
          case (sts_i.func)
            ils_pkg::FN_APPEND: begin
              cmd_o.wr_op  = ils_pkg::WR_AT_COUNT;
              cmd_o.cnt_op = ils_pkg::CNT_INC;
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
            ils_pkg::FN_DROP: begin
              cmd_o.cnt_op = ils_pkg::CNT_DEC;
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
            ils_pkg::FN_INSERT: begin
              if (sts_i.idx_eq_count) begin
                cmd_o.wr_op  = ils_pkg::WR_AT_IDX;
                cmd_o.cnt_op = ils_pkg::CNT_INC;
                cmd_o.finish = 1'b1;
                state_d      = S_IDLE;
              end else begin
                cmd_o.ptr_init = ils_pkg::PTR_CNT_M1;
                state_d        = S_SHIFT;
              end
            end
            ils_pkg::FN_REMOVE: begin
              if (sts_i.idx_last) begin
                cmd_o.cnt_op = ils_pkg::CNT_DEC;
                cmd_o.finish = 1'b1;
                state_d      = S_IDLE;
              end else begin
                cmd_o.ptr_init = ils_pkg::PTR_IDX_P1;
                state_d        = S_SHIFT;
              end
            end
            ils_pkg::FN_WRITE: begin
              cmd_o.wr_op  = ils_pkg::WR_AT_IDX;
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
            ils_pkg::FN_READ: begin
              cmd_o.rd_issue = 1'b1;
              cmd_o.rd_src   = ils_pkg::RD_IDX;
              state_d        = S_RDWAIT;
            end
            ils_pkg::FN_SEARCH: begin
              if (sts_i.empty) begin
                cmd_o.finish = 1'b1;
                state_d      = S_IDLE;
              end else begin
                cmd_o.ptr_init = ils_pkg::PTR_ZERO;
                state_d        = S_SEARCH;
              end
            end
            default: begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
          endcase
        end
      end

      // read one entry a cycle and write back the entry held by the registered read
      S_SHIFT: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.ptr_step = 1'b1;
        if (sts_i.rd_pend) begin
          cmd_o.wr_op = ils_pkg::WR_SHIFT;
        end
        if (sts_i.ptr_last) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        cmd_o.wr_op = ils_pkg::WR_SHIFT;
        if (sts_i.func == ils_pkg::FN_INSERT) begin
          state_d = S_PUT;
        end else begin
          cmd_o.cnt_op = ils_pkg::CNT_DEC;
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_PUT: begin
        cmd_o.wr_op  = ils_pkg::WR_AT_IDX;
        cmd_o.cnt_op = ils_pkg::CNT_INC;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end

      S_RDWAIT: begin
        cmd_o.finish   = 1'b1;
        cmd_o.res_kind = ils_pkg::RES_READ;
        state_d        = S_IDLE;
      end

      // compare the entry read last cycle while issuing the next read
      S_SEARCH: begin
        if (sts_i.rd_pend && sts_i.match) begin
          cmd_o.finish   = 1'b1;
          cmd_o.res_kind = ils_pkg::RES_FOUND;
          state_d        = S_IDLE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          cmd_o.ptr_step = 1'b1;
          if (sts_i.ptr_last) begin
            state_d = S_SWAIT;
          end
        end
      end

      S_SWAIT: begin
        cmd_o.finish = 1'b1;
        if (sts_i.match) begin
          cmd_o.res_kind = ils_pkg::RES_FOUND;
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result slot is free or being read out whenever a result is produced
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !sts_i.res_busy)
    else $error("result produced while the output slot is occupied");

  // an accepted request is decoded on the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted request not decoded");

  // a shift write always has read data behind it
  a_shift_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_op == ils_pkg::WR_SHIFT) |-> sts_i.rd_pend)
    else $error("shift write without read data");

endmodule

`default_nettype wire

@@ design/ils_dp.sv @@
// ----------------------------------------------------------------------------
// ils_dp: datapath of the indexed list store
// Request registers, entry memory with registered read, walk pointer,
// entry count, bounds checks and the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ils_pkg::func_e   req_func_i,
  input  wire ils_pkg::idx_t    req_index_i,
  input  wire ils_pkg::val_t    req_value_i,
  input  wire logic             rsp_ready_i,
  output      logic             rsp_valid_o,
  output      ils_pkg::status_e rsp_status_o,
  output      ils_pkg::val_t    rsp_read_value_o,
  output      logic             rsp_found_o,
  output      ils_pkg::idx_t    rsp_found_index_o,
  output      ils_pkg::ent_t    rsp_entry_count_o,
  input  wire ils_pkg::cmd_t    cmd_i,
  output      ils_pkg::sts_t    sts_o
);

  // request registers
  ils_pkg::func_e func_q;
  ils_pkg::idx_t  idx_q;
  ils_pkg::word_t val_q;

  // list state and walk
  ils_pkg::cnt_t  count_q, count_d;
  ils_pkg::addr_t ptr_q, ptr_d;
  logic           rd_pend_q;
  ils_pkg::addr_t rd_addr_q, rd_addr_d;
  ils_pkg::word_t rdata_q;
  ils_pkg::word_t mem_q [ils_pkg::DEPTH];

  // memory write port
  logic           we;
  ils_pkg::addr_t waddr;
  ils_pkg::word_t wdata;

  // result register
  logic             res_valid_q;
  ils_pkg::status_e res_status_q;
  ils_pkg::val_t    res_rd_q;
  logic             res_found_q;
  ils_pkg::idx_t    res_fidx_q;
  ils_pkg::ent_t    res_cnt_q;

  // bounds checks
  ils_pkg::cmp_t    idx_cmp;
  ils_pkg::cmp_t    cnt_cmp;
  ils_pkg::addr_t   cnt_m1;
  logic             empty;
  logic             full;
  ils_pkg::status_e err;

  assign idx_cmp = ils_pkg::cmp_t'(idx_q);
  assign cnt_cmp = ils_pkg::cmp_t'(count_q);
  assign cnt_m1  = ils_pkg::addr_t'(count_q - ils_pkg::cnt_t'(1));
  assign empty   = (count_q == '0);
  assign full    = (count_q == ils_pkg::cnt_t'(ils_pkg::DEPTH));

  // error status of the held request
  always_comb begin
    err = ils_pkg::ST_OK;
    case (func_q)
      ils_pkg::FN_APPEND: begin
        if (full) err = ils_pkg::ST_FULL;
      end
      ils_pkg::FN_DROP: begin
        if (empty) err = ils_pkg::ST_EMPTY;
      end
      ils_pkg::FN_INSERT: begin
        if (full) err = ils_pkg::ST_FULL;
        else if (idx_cmp > cnt_cmp) err = ils_pkg::ST_RANGE;
      end
      ils_pkg::FN_REMOVE, ils_pkg::FN_WRITE, ils_pkg::FN_READ: begin
        if (empty) err = ils_pkg::ST_EMPTY;
        else if (idx_cmp >= cnt_cmp) err = ils_pkg::ST_RANGE;
      end
      default: begin
        err = ils_pkg::ST_OK;
      end
    endcase
  end

  // status toward the controller
  assign sts_o.err          = err;
  assign sts_o.func         = func_q;
  assign sts_o.empty        = empty;
  assign sts_o.idx_eq_count = (idx_cmp == cnt_cmp);
  assign sts_o.idx_last     = (idx_cmp == cnt_cmp - ils_pkg::cmp_t'(1));
  assign sts_o.ptr_last     = (func_q == ils_pkg::FN_INSERT) ?
                              (ptr_q == ils_pkg::addr_t'(idx_q)) : (ptr_q == cnt_m1);
  assign sts_o.rd_pend      = rd_pend_q;
  assign sts_o.match        = (rdata_q == val_q);
  assign sts_o.res_busy     = res_valid_q && !rsp_ready_i;

  // walk pointer: down for insert, up otherwise
  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_init)
      ils_pkg::PTR_ZERO:   ptr_d = '0;
      ils_pkg::PTR_CNT_M1: ptr_d = cnt_m1;
      ils_pkg::PTR_IDX_P1: ptr_d = ils_pkg::addr_t'(idx_q) + ils_pkg::addr_t'(1);
      default: begin
        if (cmd_i.ptr_step) begin
          if (func_q == ils_pkg::FN_INSERT) ptr_d = ptr_q - ils_pkg::addr_t'(1);
          else ptr_d = ptr_q + ils_pkg::addr_t'(1);
        end
      end
    endcase
  end

  // read address
  assign rd_addr_d = (cmd_i.rd_src == ils_pkg::RD_IDX) ? ils_pkg::addr_t'(idx_q) : ptr_q;

  // write port selection
  always_comb begin
    we    = 1'b1;
    waddr = ils_pkg::addr_t'(idx_q);
    wdata = val_q;
    case (cmd_i.wr_op)
      ils_pkg::WR_AT_COUNT: waddr = ils_pkg::addr_t'(count_q);
      ils_pkg::WR_AT_IDX:   waddr = ils_pkg::addr_t'(idx_q);
      ils_pkg::WR_SHIFT: begin
        wdata = rdata_q;
        if (func_q == ils_pkg::FN_INSERT) waddr = rd_addr_q + ils_pkg::addr_t'(1);
        else waddr = rd_addr_q - ils_pkg::addr_t'(1);
      end
      default: we = 1'b0;
    endcase
  end

  // entry count update
  always_comb begin
    count_d = count_q;
    case (cmd_i.cnt_op)
      ils_pkg::CNT_INC: count_d = count_q + ils_pkg::cnt_t'(1);
      ils_pkg::CNT_DEC: count_d = count_q - ils_pkg::cnt_t'(1);
      default:          count_d = count_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_pend_q <= cmd_i.rd_issue;
      if (cmd_i.finish) begin
        res_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= req_func_i;
      idx_q  <= req_index_i;
      val_q  <= ils_pkg::word_t'(req_value_i);
    end
    ptr_q <= ptr_d;
    if (cmd_i.rd_issue) begin
      rd_addr_q <= rd_addr_d;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[rd_addr_d];
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.res_status;
      res_cnt_q    <= ils_pkg::ent_t'(count_d);
      res_rd_q     <= '0;
      res_found_q  <= 1'b0;
      res_fidx_q   <= '0;
      case (cmd_i.res_kind)
        ils_pkg::RES_READ: res_rd_q <= ils_pkg::val_t'(rdata_q);
        ils_pkg::RES_FOUND: begin
          res_found_q <= 1'b1;
          res_fidx_q  <= ils_pkg::idx_t'(rd_addr_q);
        end
        default: res_found_q <= 1'b0;
      endcase
    end
  end

  assign rsp_valid_o       = res_valid_q;
  assign rsp_status_o      = res_status_q;
  assign rsp_read_value_o  = res_rd_q;
  assign rsp_found_o       = res_found_q;
  assign rsp_found_index_o = res_fidx_q;
  assign rsp_entry_count_o = res_cnt_q;

  // the list never grows past its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ils_pkg::cnt_t'(ils_pkg::DEPTH))
    else $error("entry count above capacity");

  // growth only from a list that is not full
  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt_op == ils_pkg::CNT_INC) |-> !full)
    else $error("entry count increment on a full list");

  // shrink only from a list that is not empty
  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt_op == ils_pkg::CNT_DEC) |-> !empty)
    else $error("entry count decrement on an empty list");

endmodule

`default_nettype wire

@@ design/indexed_list_store_core.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store_core: ordered list of words with indexed access
// Append, drop, insert, remove, write, read and search on a bounded list
// held in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+------------------------------------------
//   req_i   | in  | valid/ready | func, index, value
//   rsp_o   | out | valid/ready | status, read_value, found, found_index,
//           |     |             | entry_count
//
// Append, drop, write, nop, error cases, searches of an empty list and moves
// of no entry finish straight from the decode state; a read waits for the
// registered memory read. An insert or remove that moves entries, and a
// search, walk the memory one entry per cycle through the single read port.
// One request is in work at a time; the next is taken once the result
// register is empty or being read out, so a stalled sink holds the input.
// Reset clears the entry count and all control; entry contents are left as is.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_core (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ils_req_if.sink   req_i,
  ils_rsp_if.source rsp_o
);

  ils_pkg::cmd_t cmd;
  ils_pkg::sts_t sts;

  // sequencer
  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and result path
  ils_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_func_i        (req_i.func),
    .req_index_i       (req_i.index),
    .req_value_i       (req_i.value),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_status_o      (rsp_o.status),
    .rsp_read_value_o  (rsp_o.read_value),
    .rsp_found_o       (rsp_o.found),
    .rsp_found_index_o (rsp_o.found_index),
    .rsp_entry_count_o (rsp_o.entry_count),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

`default_nettype wire

@@ tb/ils_result_checker.sv @@
// ----------------------------------------------------------------------------
// ils_result_checker: predicts and checks the results of the list store
// Watches both channels, runs a shadow list on every accepted request and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module ils_result_checker
  import ils_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ils_req_if        req_i,
  ils_rsp_if        rsp_i,
  output int        fail_count_o,
  output int        pending_o
);

  // one predicted result
  typedef struct {
    status_e status;
    val_t    read_value;
    logic    found;
    idx_t    found_index;
    ent_t    entry_count;
  } list_result_t;

  // shadow list contents and length
  word_t        shadow_words [DEPTH];
  int unsigned  shadow_len;
  list_result_t predicted_q [$];
  int           mismatches;
  int           outstanding;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // apply one request to the shadow list and return its result
  function automatic list_result_t apply_request(func_e fn, idx_t idx, val_t v);
    list_result_t r;
    int unsigned  i;
    word_t        w;
    r.status      = ST_OK;
    r.read_value  = '0;
    r.found       = 1'b0;
    r.found_index = '0;
    w = word_t'(v);
    case (fn)
      FN_APPEND: begin
        if (shadow_len >= DEPTH) r.status = ST_FULL;
        else begin
          shadow_words[shadow_len] = w;
          shadow_len++;
        end
      end
      FN_DROP: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else shadow_len--;
      end
      FN_INSERT: begin
        if (shadow_len >= DEPTH) r.status = ST_FULL;
        else if (idx > shadow_len) r.status = ST_RANGE;
        else begin
          // later entries move up by one
          for (i = shadow_len; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = w;
          shadow_len++;
        end
      end
      FN_REMOVE: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (idx >= shadow_len) r.status = ST_RANGE;
        else begin
          // later entries move down by one
          for (i = idx; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      FN_WRITE: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (idx >= shadow_len) r.status = ST_RANGE;
        else shadow_words[idx] = w;
      end
      FN_READ: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (idx >= shadow_len) r.status = ST_RANGE;
        else r.read_value = val_t'(shadow_words[idx]);
      end
      FN_SEARCH: begin
        // first position holding the word
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == w) begin
            r.found       = 1'b1;
            r.found_index = idx_t'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = ent_t'(shadow_len);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // results first: a result never belongs to a request of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      predicted_q.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: result with nothing expected, status %0h count %0d", $time,
                   rsp_i.status, rsp_i.entry_count);
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_i.status));
          check_field("read_value", 32'(want.read_value), 32'(rsp_i.read_value));
          check_field("found", 32'(want.found), 32'(rsp_i.found));
          check_field("found_index", 32'(want.found_index), 32'(rsp_i.found_index));
          check_field("entry_count", 32'(want.entry_count), 32'(rsp_i.entry_count));
        end
      end
      if (req_i.valid && req_i.ready)
        predicted_q.insert(predicted_q.size(),
                           apply_request(req_i.func, req_i.index, req_i.value));
      outstanding = predicted_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the indexed list store
// Drives directed and random list requests with bursty sending and a
// stalling receiver, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------

module tb_top;
  import ils_pkg::*;

  localparam int RAND_ITEMS = 555;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYC  = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ils_req_if req_if ();
  ils_rsp_if rsp_if ();

  int fail_count;
  int pending;

  indexed_list_store_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ils_result_checker result_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls: random stalls, with calm stretches of steady ready
  int stall_left = 0;
  int rx_cycle   = 0;
  bit rx_calm    = 1'b0;

  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  // watchdog on cycles without any item moving
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL indexed_list_store_core");
        $finish;
      end
    end
  end

  // sender state: burst length, list length seen by the stimulus, recent words
  int   burst_left = 0;
  int   list_len   = 0;
  val_t recent_vals [8];
  int   recent_wr  = 0;

  // word for a request: small pool for duplicates, recent words, extremes, random
  function automatic val_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return val_t'($urandom_range(0, 7));
    if (r < 6) return recent_vals[$urandom_range(0, 7)];
    if (r == 6) return '1;
    if (r == 7) return '0;
    return val_t'($urandom);
  endfunction

  // send one item, opening a new burst after a random gap when due
  task automatic issue_request(func_e fn, idx_t idx, val_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.func  <= fn;
    req_if.index <= idx;
    req_if.value <= v;
    do @(posedge clk_i); while (!req_if.ready);
    // keep track of the length to steer the stimulus
    case (fn)
      FN_APPEND: if (list_len < DEPTH) list_len++;
      FN_DROP:   if (list_len > 0) list_len--;
      FN_INSERT: if (list_len < DEPTH && idx <= list_len) list_len++;
      FN_REMOVE: if (list_len > 0 && idx < list_len) list_len--;
      default: ;
    endcase
    if (fn == FN_APPEND || fn == FN_INSERT || fn == FN_WRITE) begin
      recent_vals[recent_wr] = v;
      recent_wr = (recent_wr + 1) % 8;
    end
  endtask

  // hold the sender until every result is in
  task automatic wait_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  // stimulus
  initial begin
    func_e fn;
    idx_t  idx;
    int    pick;
    req_if.valid = 1'b0;
    req_if.func  = FN_NOP;
    req_if.index = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    foreach (recent_vals[i]) recent_vals[i] = val_t'(i);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: errors on the empty list, edges of index and value
    issue_request(FN_DROP,   10'd0,    32'd0);
    issue_request(FN_REMOVE, 10'd0,    32'd0);
    issue_request(FN_WRITE,  10'd0,    32'd7);
    issue_request(FN_READ,   10'd0,    32'd0);
    issue_request(FN_SEARCH, 10'd0,    32'd0);
    issue_request(FN_NOP,    10'h3FF,  32'hFFFF_FFFF);
    issue_request(FN_INSERT, 10'd1,    32'd9);
    issue_request(FN_INSERT, 10'd0,    32'hFFFF_FFFF);
    issue_request(FN_APPEND, 10'h3FF,  32'd0);
    issue_request(FN_APPEND, 10'd0,    32'h1234_5678);
    issue_request(FN_READ,   10'd0,    32'd0);
    issue_request(FN_READ,   10'd2,    32'd0);
    issue_request(FN_READ,   10'd3,    32'd0);
    issue_request(FN_WRITE,  10'd1,    32'hA5A5_A5A5);
    issue_request(FN_SEARCH, 10'd0,    32'hFFFF_FFFF);
    issue_request(FN_SEARCH, 10'd0,    32'hA5A5_A5A5);
    issue_request(FN_SEARCH, 10'd0,    32'd5);
    // insert at the length behaves as append
    issue_request(FN_INSERT, 10'd3,    32'd5);
    issue_request(FN_REMOVE, 10'd3,    32'd0);
    issue_request(FN_REMOVE, 10'd0,    32'd0);
    issue_request(FN_READ,   10'h3FF,  32'd0);
    issue_request(FN_INSERT, 10'h3FF,  32'd1);
    issue_request(FN_WRITE,  10'd2,    32'd1);
    issue_request(FN_DROP,   10'd0,    32'd0);
    issue_request(FN_NOP,    10'd0,    32'd0);
    wait_results();

    // random mix on a short list
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22)      fn = FN_APPEND;
      else if (pick < 30) fn = FN_DROP;
      else if (pick < 44) fn = FN_INSERT;
      else if (pick < 56) fn = FN_REMOVE;
      else if (pick < 68) fn = FN_WRITE;
      else if (pick < 82) fn = FN_READ;
      else if (pick < 95) fn = FN_SEARCH;
      else                fn = FN_NOP;
      // keep walks short
      if (list_len > 40 && (fn == FN_APPEND || fn == FN_INSERT)) fn = FN_DROP;
      if ($urandom_range(0, 9) < 8) idx = idx_t'($urandom_range(0, list_len));
      else idx = idx_t'($urandom);
      issue_request(fn, idx, pick_value());
      if (n == RAND_ITEMS / 2) wait_results();
    end

    // drain and verdict
    wait_results();
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS indexed_list_store_core");
    end else begin
      $display("FAIL indexed_list_store_core");
    end
    $finish;
  end

endmodule
